>>> hdl/mmgs_pkg.sv
package mmgs_pkg;
  localparam int MAX_STALLS_DEF = 1024;
  localparam int POS_W = 30;
  localparam int PC_W = 11;
  localparam logic [PC_W-1:0] PC_RESET = 11'd2;
endpackage

>>> hdl/mmgs_ram.sv
module mmgs_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/max_min_gap_selection.sv
// Channel  | Signals                                         | Direction
// input    | in_valid, in_ready, in_stall_position, in_last_item | in
// result   | out_valid, out_ready, out_largest_min_gap       | out
// config   | cfg_wr_en, cfg_wr_data (point_count)            | in
// A position is inserted in sorted order by shifting larger entries up one slot,
// one entry at a time through the single RAM port pair.
// A flagged transaction then runs up to 31 search rounds, each walking the stored
// positions in order until point_count of them are placed or the positions run out.
// Reset (synchronous, active low) empties the set and sets point_count to 2.
// Input is not ready while working; a waiting result does not block new positions.
module max_min_gap_selection #(
  parameter int MAX_STALLS = mmgs_pkg::MAX_STALLS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mmgs_pkg::POS_W-1:0] in_stall_position,
  input  logic                      in_last_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mmgs_pkg::POS_W-1:0] out_largest_min_gap,
  input  logic                      cfg_wr_en,
  input  logic [mmgs_pkg::PC_W-1:0] cfg_wr_data
);
  import mmgs_pkg::*;

  localparam int AW = $clog2(MAX_STALLS);
  localparam int CW = $clog2(MAX_STALLS + 1);
  localparam int PW = (CW > PC_W) ? CW : PC_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_IRD   = 4'd1;
  localparam logic [3:0] S_ICMP  = 4'd2;
  localparam logic [3:0] S_IPUT  = 4'd3;
  localparam logic [3:0] S_SPA   = 4'd4;
  localparam logic [3:0] S_SPB   = 4'd5;
  localparam logic [3:0] S_SPC   = 4'd6;
  localparam logic [3:0] S_MID   = 4'd7;
  localparam logic [3:0] S_TRD   = 4'd8;
  localparam logic [3:0] S_TCMP  = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [PC_W-1:0]  pc_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [POS_W-1:0] val_r, val_nxt;
  logic             last_r, last_nxt;
  logic [POS_W-1:0] first_r, first_nxt;
  logic [POS_W-1:0] prev_r, prev_nxt;
  logic [POS_W:0]   lo_r, lo_nxt;
  logic [POS_W-1:0] hi_r, hi_nxt;
  logic [POS_W-1:0] mid_r, mid_nxt;
  logic [POS_W-1:0] best_r, best_nxt;
  logic [CW-1:0]    placed_r, placed_nxt;
  logic             feas_r, feas_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_data_r, out_data_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [POS_W-1:0] wdata, rdata;
  logic [POS_W:0]   sum;
  logic [POS_W-1:0] diff;
  logic [PW-1:0]    placed_inc;

  mmgs_ram #(.WIDTH(POS_W), .DEPTH(MAX_STALLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_largest_min_gap = out_data_r;

  assign sum        = lo_r + {1'b0, hi_r};
  assign diff       = rdata - prev_r;
  assign placed_inc = PW'(placed_r) + PW'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    placed_nxt    = placed_r;
    feas_nxt      = feas_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = idx_r[AW-1:0];
    wdata         = val_r;
    raddr         = idx_r[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt  = in_stall_position;
          last_nxt = in_last_item;
          idx_nxt  = count_r;
          if (count_r >= CW'(MAX_STALLS)) begin
            state_nxt = in_last_item ? S_SPA : S_IDLE;
          end else if (count_r == '0) begin
            state_nxt = S_IPUT;
          end else begin
            state_nxt = S_IRD;
          end
        end
      end
      S_IRD: begin
        raddr     = AW'(idx_r - CW'(1));
        state_nxt = S_ICMP;
      end
      S_ICMP: begin
        we = 1'b1;
        if (rdata > val_r) begin
          wdata   = rdata;
          idx_nxt = idx_r - CW'(1);
          state_nxt = (idx_r == CW'(1)) ? S_IPUT : S_IRD;
        end else begin
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? S_SPA : S_IDLE;
        end
      end
      S_IPUT: begin
        we        = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? S_SPA : S_IDLE;
      end
      S_SPA: begin
        raddr     = '0;
        state_nxt = S_SPB;
      end
      S_SPB: begin
        first_nxt = rdata;
        raddr     = AW'(count_r - CW'(1));
        state_nxt = S_SPC;
      end
      S_SPC: begin
        hi_nxt    = rdata - first_r;
        lo_nxt    = '0;
        best_nxt  = '0;
        state_nxt = S_MID;
      end
      S_MID: begin
        if (lo_r > {1'b0, hi_r}) begin
          state_nxt = S_DONE;
        end else begin
          mid_nxt    = sum[POS_W:1];
          placed_nxt = CW'(1);
          prev_nxt   = first_r;
          idx_nxt    = CW'(1);
          if (pc_r <= PC_W'(1)) begin
            feas_nxt  = 1'b1;
            state_nxt = S_UPD;
          end else begin
            state_nxt = S_TRD;
          end
        end
      end
      S_TRD: begin
        if (idx_r >= count_r) begin
          feas_nxt  = 1'b0;
          state_nxt = S_UPD;
        end else begin
          state_nxt = S_TCMP;
        end
      end
      S_TCMP: begin
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_TRD;
        if (diff >= mid_r) begin
          prev_nxt   = rdata;
          placed_nxt = placed_r + CW'(1);
          if (placed_inc >= PW'(pc_r)) begin
            feas_nxt  = 1'b1;
            state_nxt = S_UPD;
          end
        end
      end
      S_UPD: begin
        state_nxt = S_MID;
        if (feas_r) begin
          best_nxt = mid_r;
          lo_nxt   = {1'b0, mid_r} + (POS_W+1)'(1);
        end else if (mid_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          hi_nxt = mid_r - POS_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_r;
          count_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pc_r        <= PC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end
    end
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    first_r    <= first_nxt;
    prev_r     <= prev_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    best_r     <= best_nxt;
    placed_r   <= placed_nxt;
    feas_r     <= feas_nxt;
    out_data_r <= out_data_nxt;
  end
endmodule

>>> test/tb_max_min_gap_selection.sv
`timescale 1ns / 1ps

module tb_max_min_gap_selection;
  import mmgs_pkg::*;

  typedef struct {
    logic [POS_W-1:0] pos;
    logic             last;
    logic             has_gap;
    logic [POS_W-1:0] gap;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [POS_W-1:0] in_stall_position;
  logic             in_last_item;
  logic             out_valid;
  logic             out_ready;
  logic [POS_W-1:0] out_largest_min_gap;
  logic             cfg_wr_en;
  logic [PC_W-1:0]  cfg_wr_data;

  logic [POS_W-1:0] sorted_stalls[$];
  logic [PC_W-1:0]  pred_point_count;
  logic [POS_W-1:0] expected_gaps[$];
  int               error_count;
  int               items_sent;
  int               gaps_seen;
  int               sets_sent;
  bit               quiet_tail;

  max_min_gap_selection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_stall_position(in_stall_position), .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_largest_min_gap(out_largest_min_gap),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #50ms;
    $display("tb_max_min_gap_selection failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic bit greedy_fits(input logic [POS_W-1:0] gap);
    int unsigned placed;
    logic [POS_W-1:0] prev;
    placed = 1;
    if (placed >= pred_point_count) return 1'b1;
    prev = sorted_stalls[0];
    for (int i = 1; i < sorted_stalls.size(); i++) begin
      if (sorted_stalls[i] - prev >= gap) begin
        prev = sorted_stalls[i];
        placed++;
        if (placed >= pred_point_count) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [POS_W-1:0] widest_gap();
    longint lo, hi, mid, best;
    best = 0;
    lo = 0;
    if (sorted_stalls.size() == 0) return '0;
    hi = sorted_stalls[sorted_stalls.size()-1] - sorted_stalls[0];
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (greedy_fits(mid[POS_W-1:0])) begin
        best = mid;
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return best[POS_W-1:0];
  endfunction

  function automatic void add_stall(input logic [POS_W-1:0] pos, input logic last);
    int k;
    k = 0;
    if (sorted_stalls.size() < MAX_STALLS_DEF) begin
      while (k < sorted_stalls.size() && sorted_stalls[k] <= pos) k++;
      sorted_stalls.insert(k, pos);
    end
    if (last) begin
      expected_gaps.push_back(widest_gap());
      sorted_stalls.delete();
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      gaps_seen++;
      if (expected_gaps.size() == 0) begin
        report_mismatch($sformatf("unexpected gap %0d", out_largest_min_gap));
      end else begin
        if (out_largest_min_gap !== expected_gaps[0])
          report_mismatch($sformatf("gap %0d, expected %0d",
                                    out_largest_min_gap, expected_gaps[0]));
        void'(expected_gaps.pop_front());
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (1) begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  task automatic send_stall(input logic [POS_W-1:0] pos, input logic last);
    if (!quiet_tail && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 18)) @(negedge clk);
    in_valid = 1'b1;
    in_stall_position = pos;
    in_last_item = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    add_stall(pos, last);
    items_sent++;
    if (last) sets_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (expected_gaps.size() != 0 && guard < 2000000) begin
      @(negedge clk);
      guard++;
    end
    repeat (200) @(negedge clk);
  endtask

  task automatic set_point_count(input logic [PC_W-1:0] value);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    pred_point_count = value;
  endtask

  task automatic send_random_set(input int n, input logic [POS_W-1:0] span);
    for (int i = 0; i < n; i++)
      send_stall(POS_W'($urandom_range(0, span)), i == n - 1);
  endtask

  stim_row_t directed[] = '{
    '{30'd5, 1'b1, 1'b1, 30'd0},
    '{30'd0, 1'b0, 1'b0, 30'd0},
    '{30'h3FFFFFFF, 1'b1, 1'b1, 30'h3FFFFFFF},
    '{30'd7, 1'b0, 1'b0, 30'd0},
    '{30'd7, 1'b1, 1'b1, 30'd0},
    '{30'd9, 1'b0, 1'b0, 30'd0},
    '{30'd1, 1'b0, 1'b0, 30'd0},
    '{30'd4, 1'b0, 1'b0, 30'd0},
    '{30'd2, 1'b1, 1'b1, 30'd8},
    '{30'h2AAAAAAA, 1'b0, 1'b0, 30'd0},
    '{30'h15555555, 1'b1, 1'b1, 30'h15555555}
  };

  initial begin
    logic [PC_W-1:0] pc_list[] = '{11'd3, 11'd1024, 11'd0, 11'd1, 11'd5, 11'd2047,
                                   11'd4, 11'd2};
    in_valid = 1'b0;
    in_stall_position = '0;
    in_last_item = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rst_n = 1'b0;
    quiet_tail = 1'b0;
    error_count = 0;
    items_sent = 0;
    gaps_seen = 0;
    sets_sent = 0;
    pred_point_count = PC_RESET;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      send_stall(directed[i].pos, directed[i].last);
      if (directed[i].has_gap && expected_gaps.size() != 0
          && expected_gaps[expected_gaps.size()-1] !== directed[i].gap)
        report_mismatch($sformatf("predictor disagrees with table at row %0d", i));
    end

    set_point_count(11'd1025);
    send_random_set(3, 100);

    foreach (pc_list[p]) begin
      set_point_count(pc_list[p]);
      for (int s = 0; s < 23; s++) begin
        if (s == 11) drain();
        if (p == pc_list.size() - 1 && s >= 15) quiet_tail = 1'b1;
        case ($urandom_range(0, 2))
          0: send_random_set($urandom_range(1, 12), 30'h3FFFFFFF);
          1: send_random_set($urandom_range(2, 8), 30'd40);
          default: send_random_set($urandom_range(1, 6), 30'd3);
        endcase
      end
    end

    drain();
    $display("Sent %0d stall positions in %0d sets; %0d gaps checked.",
             items_sent, sets_sent, gaps_seen);
    $display("Point counts from 0 to 2047 were used, including counts above the set size.");
    if (error_count == 0 && expected_gaps.size() == 0) begin
      $display("tb_max_min_gap_selection passed");
    end else begin
      $display("tb_max_min_gap_selection failed");
    end
    $finish;
  end
endmodule

>>> max_min_gap_selection.f
hdl/mmgs_pkg.sv
hdl/mmgs_ram.sv
hdl/max_min_gap_selection.sv
test/tb_max_min_gap_selection.sv
